FILE: rtl/core/assert_macros.svh
// assertion macros used by the port checker file
// no dependencies; include once per compilation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

FILE: rtl/core/stepseq_pkg.sv
// types and constants for the step/direction sequencer
// no dependencies; imported by the top level and the port checker
`default_nettype none

package stepseq_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int SETTLE_W           = 16;
    localparam int COUNT_W            = 32;
    localparam int REMAIN_W           = 31;
    localparam int POS_OUT_W          = 32;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd10;

    // stream data layouts
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_USED_W  = 68;

    localparam int OUT_MODE_LSB  = 0;
    localparam int OUT_DIR_BIT   = 2;
    localparam int OUT_PULSE_BIT = 3;
    localparam int OUT_POS_LSB   = 4;
    localparam int OUT_LEFT_LSB  = 36;
    localparam int OUT_AWAKE_BIT = 67;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BUSY  = 2'd1,
        MODE_STAB  = 2'd2,
        MODE_SLEEP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_MOVE  = 3'd1,
        OP_STOP  = 3'd2,
        OP_SLEEP = 3'd3,
        OP_WAKE  = 3'd4
    } op_t;

endpackage

`default_nettype wire

FILE: rtl/core/stepper_step_dir_sequencer.sv
// step/direction stepper sequencer, top level
// depends on stepseq_pkg; checked by stepseq_checker (bound from its own file)
`default_nettype none

// Takes one event per transfer (tick, move, stop, sleep, wakeup) and returns one
// status item per event showing the sequencer state after it. Throughput is one
// event per clock while the output buffer is not full: an event lands in an input
// register, the state update and the result are formed in one pass of short logic
// (one 32-bit negate for the move magnitude, one position increment/decrement),
// and the result goes into a two-entry output buffer. Input tready depends only
// on internal registers, so a result waiting at the output does not block the
// next event until the buffer is full. A move whose sign reverses the direction
// line enters a settle wait of settle_ticks ticks plus one before stepping; a zero
// count means counterclockwise. settle_ticks is written through the cfg channel
// (always ready); the user must write it only while idle, the block does not
// enforce this. POSITION_WIDTH sets the position counter width; the reported
// position is its low 32 bits, sign-extended when the counter is narrower.
module stepper_step_dir_sequencer
    import stepseq_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration write
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [SETTLE_W-1:0]      cfg_data,     // settle_ticks
    // event stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]    s_axis_tdata, // [31:0] step_count
    input  wire logic [2:0]               s_axis_tuser, // [2:0] operation
    // status stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]        m_axis_tdata  // [1:0] mode, [2] direction,
                                                        // [3] step_pulse, [35:4] position,
                                                        // [66:36] steps_left, [67] awake,
                                                        // [71:68] zero
);

    // configuration
    logic [SETTLE_W-1:0] settle_ticks_reg;

    // input register
    logic                in_valid_reg;
    logic [2:0]          op_reg;
    logic [COUNT_W-1:0]  count_reg;

    // sequencer state
    mode_t                    mode_reg, mode_next;
    logic                     direction_reg, direction_next;
    logic [REMAIN_W-1:0]      remaining_reg, remaining_next;
    logic [POSITION_WIDTH-1:0] position_reg, position_next;
    logic [SETTLE_W-1:0]      settle_reg, settle_next;
    logic                     awake_reg, awake_next;
    logic                     pulse;

    // output buffer: head drives the port, skid catches a result while head stalls
    logic                    head_valid_reg, skid_valid_reg;
    logic [OUT_TDATA_W-1:0]  head_reg, skid_reg;
    logic [OUT_TDATA_W-1:0]  result;

    logic fire;
    logic pop;
    logic in_xfer;

    // move magnitude
    logic                neg;
    logic                want_cw;
    logic [COUNT_W-1:0]  mag;
    logic [REMAIN_W-1:0] mag_sat;
    logic [POS_OUT_W-1:0] pos_out;

    assign cfg_ready     = 1'b1;
    assign fire          = in_valid_reg && !skid_valid_reg;
    assign s_axis_tready = !in_valid_reg || !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign pop           = head_valid_reg && m_axis_tready;

    assign m_axis_tvalid = head_valid_reg;
    assign m_axis_tdata  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            settle_ticks_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= s_axis_tuser;
            count_reg <= s_axis_tdata;
        end
    end

    // magnitude of the signed count, most negative value saturates
    always_comb
    begin
        neg     = count_reg[COUNT_W-1];
        want_cw = !neg && (count_reg != '0);
        mag     = neg ? (COUNT_W'(0) - count_reg) : count_reg;
        mag_sat = mag[COUNT_W-1] ? {REMAIN_W{1'b1}} : mag[REMAIN_W-1:0];
    end

    // event decode and state update
    always_comb
    begin
        mode_next      = mode_reg;
        direction_next = direction_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        settle_next    = settle_reg;
        awake_next     = awake_reg;
        pulse          = 1'b0;

        case (op_t'(op_reg))
            OP_TICK:
            begin
                if (mode_reg == MODE_BUSY)
                begin
                    if (remaining_reg != '0)
                    begin
                        remaining_next = remaining_reg - REMAIN_W'(1);
                        position_next  = direction_reg ? position_reg + POSITION_WIDTH'(1)
                                                       : position_reg - POSITION_WIDTH'(1);
                        pulse          = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                else if (mode_reg == MODE_STAB)
                begin
                    // count the settle wait down, the tick that finds zero enters busy mode
                    if (settle_reg != '0)
                    begin
                        settle_next = settle_reg - SETTLE_W'(1);
                    end
                    else
                    begin
                        mode_next = MODE_BUSY;
                    end
                end
            end
            OP_MOVE:
            begin
                if (mode_reg != MODE_SLEEP)
                begin
                    remaining_next = mag_sat;
                    if (want_cw != direction_reg)
                    begin
                        direction_next = want_cw;
                        mode_next      = MODE_STAB;
                        settle_next    = settle_ticks_reg;
                    end
                    else
                    begin
                        mode_next = MODE_BUSY;
                    end
                end
            end
            OP_STOP:
            begin
                if (mode_reg != MODE_SLEEP)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            OP_SLEEP:
            begin
                mode_next  = MODE_SLEEP;
                awake_next = 1'b0;
            end
            OP_WAKE:
            begin
                mode_next  = MODE_IDLE;
                awake_next = 1'b1;
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            direction_reg <= 1'b0;
            remaining_reg <= '0;
            position_reg  <= '0;
            settle_reg    <= '0;
            awake_reg     <= 1'b1;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            direction_reg <= direction_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            settle_reg    <= settle_next;
            awake_reg     <= awake_next;
        end
    end

    // reported position: low bits of the counter, sign-extended if narrower
    assign pos_out = POS_OUT_W'($signed(position_next));

    assign result = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, awake_next, remaining_next, pos_out,
                     pulse, direction_next, mode_next};

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (!head_valid_reg || pop)
                begin
                    head_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                head_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (!head_valid_reg || pop)
            begin
                head_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            head_reg <= skid_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stepseq_checker.sv
// port-level checks for the step/direction sequencer, bound to the top level
// depends on stepseq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stepseq_checker
    import stepseq_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [1:0] out_mode;
    logic       out_pulse;
    logic       out_awake;

    assign out_mode  = m_axis_tdata[OUT_MODE_LSB +: 2];
    assign out_pulse = m_axis_tdata[OUT_PULSE_BIT];
    assign out_awake = m_axis_tdata[OUT_AWAKE_BIT];

    // a step pulse only comes out of busy mode
    `CHK_IMPL(pulse_only_busy, clk, rst_n, m_axis_tvalid && out_pulse, out_mode == MODE_BUSY)

    // driver enable is low exactly while sleeping
    `CHK_IMPL(awake_matches_sleep, clk, rst_n, m_axis_tvalid,
              (out_awake == 1'b0) == (out_mode == MODE_SLEEP))

    // a stalled status transfer holds its data
    `CHK_NEXT(out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind stepper_step_dir_sequencer stepseq_checker u_stepseq_checker (.*);

`default_nettype wire

FILE: sim/tb_stepper_step_dir_sequencer.sv
// self-checking testbench for the step/direction stepper sequencer
// depends on stepseq_pkg and stepper_step_dir_sequencer from the rtl tree
// directed event table, then random move/tick runs checked by an in-bench motion predictor
module tb_stepper_step_dir_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import stepseq_pkg::*;

    // operation codes the block must ignore
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;
    // cycles to let the pipeline settle after the last status transfer
    localparam int TAIL_CYCLES = 10;

    // one status item, unpacked from the output stream
    typedef struct packed {
        mode_t       mode;
        logic        dir;
        logic        pulse;
        logic [31:0] position;
        logic [30:0] steps_left;
        logic        awake;
    } status_t;

    // directed stimulus: the expected status is typed in only where it is obvious
    typedef struct {
        logic [2:0]  op;
        logic [31:0] count;
        bit          typed;
        status_t     want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SETTLE_W-1:0]    cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] step_count
    logic [2:0]             s_axis_tuser;   // [2:0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [1:0] mode, [2] direction, [3] step_pulse,
                                            // [35:4] position, [66:36] steps_left, [67] awake

    // motion predictor state, mirrors the sequencer registers
    mode_t         motion_mode;
    logic          motion_dir;
    logic [30:0]   motion_left;
    logic [31:0]   motion_pos;
    logic [15:0]   motion_settle;
    logic          motion_awake;
    logic [15:0]   settle_ticks;

    status_t       status_q[$];     // status items still owed by the block
    status_t       due;
    stim_row_t     directed[$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    localparam status_t NO_STATUS = '{MODE_IDLE, 1'b0, 1'b0, 32'd0, 31'd0, 1'b0};

    stepper_step_dir_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic status_t st(mode_t m, logic d, logic p, logic [31:0] pos,
                                   logic [30:0] left, logic a);
        status_t s;
        s.mode = m;
        s.dir = d;
        s.pulse = p;
        s.position = pos;
        s.steps_left = left;
        s.awake = a;
        return s;
    endfunction

    // apply one event to the predictor and return the status it should report
    function automatic status_t advance(input logic [2:0] op, input logic [31:0] count);
        logic        pulse;
        logic        want_cw;
        logic [31:0] mag;
        pulse = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (motion_mode == MODE_BUSY)
                begin
                    if (motion_left != 31'd0)
                    begin
                        // one step in the current direction
                        motion_left = motion_left - 31'd1;
                        motion_pos = motion_dir ? motion_pos + 32'd1 : motion_pos - 32'd1;
                        pulse = 1'b1;
                    end
                    else
                        motion_mode = MODE_IDLE;
                end
                else if (motion_mode == MODE_STAB)
                begin
                    // settle countdown, the tick that finds zero enters busy mode
                    if (motion_settle != 16'd0)
                        motion_settle = motion_settle - 16'd1;
                    else
                        motion_mode = MODE_BUSY;
                end
            end
            OP_MOVE:
            begin
                if (motion_mode != MODE_SLEEP)
                begin
                    // zero or negative count means counterclockwise
                    want_cw = !count[31] && (count != 32'd0);
                    mag = count[31] ? (32'd0 - count) : count;
                    if (mag > 32'h7FFF_FFFF)
                        mag = 32'h7FFF_FFFF;
                    motion_left = mag[30:0];
                    if (want_cw != motion_dir)
                    begin
                        motion_dir = want_cw;
                        motion_mode = MODE_STAB;
                        motion_settle = settle_ticks;
                    end
                    else
                        motion_mode = MODE_BUSY;
                end
            end
            OP_STOP:
            begin
                if (motion_mode != MODE_SLEEP)
                    motion_mode = MODE_IDLE;
            end
            OP_SLEEP:
            begin
                motion_mode = MODE_SLEEP;
                motion_awake = 1'b0;
            end
            OP_WAKE:
            begin
                motion_mode = MODE_IDLE;
                motion_awake = 1'b1;
            end
            default:
            begin
            end
        endcase
        return st(motion_mode, motion_dir, pulse, motion_pos, motion_left, motion_awake);
    endfunction

    function automatic logic [2:0] noise_op();
        case ($urandom_range(9))
            0:       return OP_SLEEP;
            1, 2, 3: return OP_WAKE;
            4, 5:    return OP_STOP;
            6:       return OP_TICK;
            7:       return OP_MOVE;
            default: return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // one event transfer; the expectation is queued at the edge that accepts it
    task automatic send_event(input logic [2:0] op, input logic [31:0] count,
                              input bit typed, input status_t want);
        status_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tuser = op;
        s_axis_tdata = count;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = advance(op, count);
        status_q.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic wait_status_drained();
        s_axis_tvalid = 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // settle_ticks write, only issued once every outstanding status item is back
    task automatic write_settle(input logic [15:0] value);
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        settle_ticks = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly move commands followed by tick runs, with stray events mixed in
    task automatic random_events(input int target);
        int          done;
        int          span;
        logic [31:0] cnt;
        done = 0;
        while (done < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                case ($urandom_range(9))
                    0:       cnt = 32'd0;
                    1:       cnt = $urandom();
                    2:       cnt = 32'h8000_0000;
                    default:
                    begin
                        cnt = 32'($urandom_range(1, 12));
                        if ($urandom_range(1) != 0)
                            cnt = 32'd0 - cnt;
                    end
                endcase
                send_event(OP_MOVE, cnt, 1'b0, NO_STATUS);
                done++;
                span = 16 + ((settle_ticks > 16'd20) ? 20 : int'(settle_ticks));
                repeat ($urandom_range(0, span))
                begin
                    if ($urandom_range(99) < 4)
                        send_event(noise_op(), $urandom(), 1'b0, NO_STATUS);
                    else
                        send_event(OP_TICK, $urandom(), 1'b0, NO_STATUS);
                    done++;
                end
            end
            else
            begin
                send_event(noise_op(), $urandom(), 1'b0, NO_STATUS);
                done++;
            end
        end
    endtask

    // drain, reconfigure, then run random events under the given idling
    task automatic run_phase(input logic [15:0] settle, input int send_pct,
                             input int recv_pct, input int items);
        wait_status_drained();
        write_settle(settle);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        random_events(items);
    endtask

    // receiver: random stalls plus an occasional long hold-off counted here
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each status transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (status_q.size() == 0)
            begin
                $error("status transfer with no event outstanding");
                error_count++;
            end
            else
            begin
                due = status_q.pop_front();
                check_field("mode", 32'(due.mode), 32'(m_axis_tdata[OUT_MODE_LSB +: 2]));
                check_field("direction", 32'(due.dir), 32'(m_axis_tdata[OUT_DIR_BIT]));
                check_field("step_pulse", 32'(due.pulse), 32'(m_axis_tdata[OUT_PULSE_BIT]));
                check_field("position", due.position, m_axis_tdata[OUT_POS_LSB +: 32]);
                check_field("steps_left", 32'(due.steps_left),
                            32'(m_axis_tdata[OUT_LEFT_LSB +: REMAIN_W]));
                check_field("awake", 32'(due.awake), 32'(m_axis_tdata[OUT_AWAKE_BIT]));
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;

        // predictor reset state
        motion_mode = MODE_IDLE;
        motion_dir = 1'b0;
        motion_left = '0;
        motion_pos = '0;
        motion_settle = '0;
        motion_awake = 1'b1;
        settle_ticks = SETTLE_RESET;

        // directed table, run with the reset settle time
        directed.push_back('{OP_TICK, 32'd0, 1'b1, st(MODE_IDLE, 0, 0, 32'd0, 31'd0, 1)});
        directed.push_back('{OP_MOVE, 32'd0, 1'b1, st(MODE_BUSY, 0, 0, 32'd0, 31'd0, 1)});
        // busy with nothing left goes idle without a pulse
        directed.push_back('{OP_TICK, 32'd0, 1'b1, st(MODE_IDLE, 0, 0, 32'd0, 31'd0, 1)});
        directed.push_back('{OP_MOVE, 32'hFFFF_FFFE, 1'b1,
                             st(MODE_BUSY, 0, 0, 32'd0, 31'd2, 1)});
        // position wraps below zero
        directed.push_back('{OP_TICK, 32'd0, 1'b1,
                             st(MODE_BUSY, 0, 1, 32'hFFFF_FFFF, 31'd1, 1)});
        // stop keeps the remaining count
        directed.push_back('{OP_STOP, 32'd0, 1'b1,
                             st(MODE_IDLE, 0, 0, 32'hFFFF_FFFF, 31'd1, 1)});
        // most negative count saturates
        directed.push_back('{OP_MOVE, 32'h8000_0000, 1'b1,
                             st(MODE_BUSY, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1)});
        // reversal enters the settle wait
        directed.push_back('{OP_MOVE, 32'h7FFF_FFFF, 1'b1,
                             st(MODE_STAB, 1, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1)});
        directed.push_back('{OP_TICK, 32'd0, 1'b0, NO_STATUS});
        // same-direction move cuts the settle wait short
        directed.push_back('{OP_MOVE, 32'd5, 1'b0, NO_STATUS});
        directed.push_back('{OP_TICK, 32'd0, 1'b0, NO_STATUS});
        directed.push_back('{OP_SLEEP, 32'd0, 1'b1, st(MODE_SLEEP, 1, 0, 32'd0, 31'd4, 0)});
        // move, stop, tick and spare codes are all ignored while sleeping
        directed.push_back('{OP_MOVE, 32'd3, 1'b0, NO_STATUS});
        directed.push_back('{OP_STOP, 32'd0, 1'b0, NO_STATUS});
        directed.push_back('{OP_TICK, 32'd0, 1'b0, NO_STATUS});
        directed.push_back('{OP_SPARE_LO, 32'd0, 1'b0, NO_STATUS});
        directed.push_back('{OP_SPARE_HI, 32'hFFFF_FFFF, 1'b0, NO_STATUS});
        directed.push_back('{OP_WAKE, 32'd0, 1'b1, st(MODE_IDLE, 1, 0, 32'd0, 31'd4, 1)});
        directed.push_back('{OP_MOVE, 32'hFFFF_FFFF, 1'b0, NO_STATUS});
        // wakeup cancels a settle wait
        directed.push_back('{OP_WAKE, 32'd0, 1'b1, st(MODE_IDLE, 0, 0, 32'd0, 31'd1, 1)});
        directed.push_back('{OP_MOVE, 32'd1, 1'b0, NO_STATUS});
        // stop from the settle wait
        directed.push_back('{OP_STOP, 32'd0, 1'b0, NO_STATUS});
        directed.push_back('{OP_MOVE, 32'd1, 1'b0, NO_STATUS});
        directed.push_back('{OP_TICK, 32'd0, 1'b0, NO_STATUS});
        directed.push_back('{OP_TICK, 32'd0, 1'b0, NO_STATUS});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_event(directed[i].op, directed[i].count, directed[i].typed,
                       directed[i].want);

        // random phases: settle time, sender idle %, receiver stall %, events
        run_phase(16'd0, 0, 0, 330);
        run_phase(16'd3, 68, 0, 330);
        run_phase(16'd1, 0, 68, 330);
        run_phase(16'd7, 19, 19, 330);
        run_phase(16'hFFFF, 0, 0, 150);

        // long receiver hold-off while events keep coming, so the block backs up
        wait_status_drained();
        write_settle(16'd2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_requests++;
        @(negedge clk);
        random_events(60);

        // sender pauses until every status item is back, then carries on
        run_phase(SETTLE_RESET, 19, 19, 320);

        wait_status_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
